// File: rtl/fopi_pkg.sv
`timescale 1ns / 1ps
package fopi_pkg;

  localparam int IDX_W  = 16;
  localparam int STEP_W = 9;
  localparam int SPAN_W = 8;
  localparam int POS_W  = 18;
  localparam int MAG_W  = 17;
  localparam int MEM_W  = 32;
  localparam int CMD_W  = 2;
  localparam int BITS_W = 5;

  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NEXT    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  localparam logic REG_REAR_SPAN  = 1'b0;
  localparam logic REG_FRONT_SPAN = 1'b1;

  localparam logic [MEM_W-1:0] MEM_LOW_LIMIT  = 32'd31500000;
  localparam logic [MEM_W-1:0] MEM_HIGH_LIMIT = 32'd52500000;
  localparam logic [SPAN_W-1:0] SPAN_TIGHT    = 8'd3;
  localparam logic [SPAN_W-1:0] SPAN_MINIMAL  = 8'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_POS,
    ST_GO_A,
    ST_WAIT_A,
    ST_GO_B,
    ST_WAIT_B,
    ST_JUDGE,
    ST_EMIT
  } fsm_state_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] value;
    logic [IDX_W-1:0] modulus;
  } wrap_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] result;
  } wrap_rsp_t;

endpackage

// File: rtl/fopi_wrap.sv
`timescale 1ns / 1ps
module fopi_wrap
  import fopi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  wrap_req_t req,
  output wrap_rsp_t rsp
);

  logic              busy;
  logic              fix;
  logic              neg;
  logic [BITS_W-1:0] bit_cnt;
  logic [MAG_W-1:0]  mag;
  logic [IDX_W-1:0]  rem;
  logic [IDX_W-1:0]  modulus;
  logic [IDX_W-1:0]  result;
  logic              done;
  logic [IDX_W:0]    trial;
  logic [POS_W-1:0]  neg_value;
  logic [IDX_W-1:0]  rem_next;

  always_comb begin
    neg_value = -req.value;
    trial     = {rem, mag[MAG_W-1]};
    if (trial >= {1'b0, modulus}) begin
      rem_next = IDX_W'(trial - {1'b0, modulus});
    end else begin
      rem_next = trial[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        fix     <= 1'b0;
        neg     <= req.value[POS_W-1];
        mag     <= req.value[POS_W-1] ? neg_value[MAG_W-1:0] : req.value[MAG_W-1:0];
        modulus <= req.modulus;
        rem     <= '0;
        bit_cnt <= BITS_W'(MAG_W - 1);
      end else if (busy) begin
        rem <= rem_next;
        mag <= {mag[MAG_W-2:0], 1'b0};
        if (bit_cnt == '0) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end else begin
          bit_cnt <= bit_cnt - 1'b1;
        end
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
        // negative operand folds back from the top of the range
        if (neg && rem != '0) begin
          result <= modulus - rem;
        end else begin
          result <= rem;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

// File: rtl/focus_outward_prefetch_index.sv
`timescale 1ns / 1ps
// a next command that fetches runs one modulo pass, a window query that runs both
// bounds runs two; restart and the short-cut cases bypass the modulo unit
// throughput: one beat at a time; the next beat is taken once the result is
// in the output register, set by the 17-step bit-serial modulo unit
// reset (rst, synchronous): walk step, spans and live spans cleared to zero
module focus_outward_prefetch_index
  import fopi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // list_count, focus_position, free_bytes, probe_index
  input  logic [1:0]  s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // next_index, in_window, zero fill
  output logic        m_axis_tuser   // found
);

  fsm_state_t state;
  fsm_state_t state_next;

  logic [SPAN_W-1:0] rear_span;
  logic [SPAN_W-1:0] front_span;
  logic [SPAN_W-1:0] live_rear;
  logic [SPAN_W-1:0] live_front;
  logic [STEP_W-1:0] step;

  logic [CMD_W-1:0]  cmd;
  logic [IDX_W-1:0]  cnt;
  logic [IDX_W-1:0]  focus;
  logic [MEM_W-1:0]  free_mem;
  logic [IDX_W-1:0]  probe;

  logic [POS_W-1:0]  op_val;
  logic [IDX_W-1:0]  first;
  logic [IDX_W-1:0]  last;
  logic [IDX_W-1:0]  res_idx;
  logic              res_found;
  logic              res_inwin;

  wrap_req_t wreq;
  wrap_rsp_t wrsp;

  logic              in_beat;
  logic              out_free;
  logic [STEP_W-1:0] sum_span;
  logic              walk_end;
  logic              window_all;
  logic [SPAN_W-1:0] lo;
  logic [STEP_W-1:0] step_inc;
  logic [STEP_W-1:0] off;
  logic [POS_W-1:0]  pos;
  logic              spans_big;
  logic              mem_mid;
  logic              mem_low;
  logic              restore;

  fopi_wrap u_wrap (
    .clk (clk),
    .rst (rst),
    .req (wreq),
    .rsp (wrsp)
  );

  always_comb begin
    in_beat    = s_axis_tvalid && s_axis_tready;
    out_free   = !m_axis_tvalid || m_axis_tready;
    sum_span   = {1'b0, live_front} + {1'b0, live_rear};
    walk_end   = (sum_span < step) || (cnt <= {{(IDX_W-STEP_W){1'b0}}, step});
    window_all = cnt <= {{(IDX_W-STEP_W){1'b0}}, sum_span};
    lo         = (live_front < live_rear) ? live_front : live_rear;
    step_inc   = step + 1'b1;
    off        = step - {1'b0, lo};
    if (step <= {lo, 1'b0}) begin
      if (!step[0]) begin
        pos = {2'b00, focus} - {{(POS_W-SPAN_W){1'b0}}, step_inc[STEP_W-1:1]};
      end else begin
        pos = {2'b00, focus} + {{(POS_W-SPAN_W){1'b0}}, step_inc[STEP_W-1:1]};
      end
    end else if (live_rear < live_front) begin
      pos = {2'b00, focus} + {{(POS_W-STEP_W){1'b0}}, off};
    end else begin
      pos = {2'b00, focus} - {{(POS_W-STEP_W){1'b0}}, off};
    end
    spans_big = (front_span > SPAN_TIGHT) && (rear_span > SPAN_TIGHT);
    mem_mid   = (free_mem < MEM_HIGH_LIMIT) && (free_mem > MEM_LOW_LIMIT);
    mem_low   = free_mem < MEM_LOW_LIMIT;
    restore   = (live_front != front_span) && (live_rear != rear_span);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_beat) state_next = ST_PREP;
      end
      ST_PREP: begin
        case (cmd)
          CMD_NEXT:  state_next = (cnt == '0) ? ST_EMIT : ST_POS;
          CMD_QUERY: state_next = window_all ? ST_EMIT : ST_GO_A;
          default:   state_next = ST_EMIT;
        endcase
      end
      ST_POS: begin
        state_next = walk_end ? ST_EMIT : ST_GO_A;
      end
      ST_GO_A: begin
        state_next = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        if (wrsp.done) state_next = (cmd == CMD_QUERY) ? ST_GO_B : ST_EMIT;
      end
      ST_GO_B: begin
        state_next = ST_WAIT_B;
      end
      ST_WAIT_B: begin
        if (wrsp.done) state_next = ST_JUDGE;
      end
      ST_JUDGE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    wreq.start    = 1'b0;
    wreq.value    = op_val;
    wreq.modulus  = cnt;
    case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_GO_A: wreq.start    = 1'b1;
      ST_GO_B: wreq.start    = 1'b1;
      default: s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rear_span     <= '0;
      front_span    <= '0;
      live_rear     <= '0;
      live_front    <= '0;
      step          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready && state != ST_EMIT) m_axis_tvalid <= 1'b0;

      if (cfg_wr_en) begin
        if (cfg_index == REG_REAR_SPAN) begin
          rear_span <= cfg_data;
          live_rear <= cfg_data;
        end else begin
          front_span <= cfg_data;
          live_front <= cfg_data;
        end
      end

      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            cmd       <= s_axis_tuser;
            cnt       <= s_axis_tdata[15:0];
            focus     <= s_axis_tdata[31:16];
            free_mem  <= s_axis_tdata[63:32];
            probe     <= s_axis_tdata[79:64];
            res_idx   <= '0;
            res_found <= 1'b0;
            res_inwin <= 1'b0;
          end
        end
        ST_PREP: begin
          case (cmd)
            CMD_RESTART: step <= '0;
            CMD_NEXT: begin
              // memory pressure narrows the live spans; otherwise they widen back to the configured spans
              if (cnt != '0 && spans_big) begin
                if (mem_mid) begin
                  live_front <= SPAN_TIGHT;
                  live_rear  <= SPAN_TIGHT;
                end else if (mem_low) begin
                  live_front <= SPAN_MINIMAL;
                  live_rear  <= SPAN_MINIMAL;
                end else if (restore) begin
                  if (front_span > live_front) live_front <= front_span;
                  if (rear_span > live_rear)   live_rear  <= rear_span;
                end
              end
            end
            CMD_QUERY: begin
              if (window_all) begin
                res_inwin <= 1'b1;
              end else begin
                op_val <= {2'b00, focus} - {{(POS_W-SPAN_W){1'b0}}, live_rear};
              end
            end
            default: res_inwin <= 1'b0;
          endcase
        end
        ST_POS: begin
          op_val <= pos;
        end
        ST_WAIT_A: begin
          if (wrsp.done) begin
            if (cmd == CMD_QUERY) begin
              first  <= wrsp.result;
              op_val <= {2'b00, focus} + {{(POS_W-SPAN_W){1'b0}}, live_front};
            end else begin
              res_idx   <= wrsp.result;
              res_found <= 1'b1;
              step      <= step_inc;
            end
          end
        end
        ST_WAIT_B: begin
          if (wrsp.done) last <= wrsp.result;
        end
        ST_JUDGE: begin
          if (first <= last) begin
            res_inwin <= (probe >= first) && (probe <= last);
          end else begin
            res_inwin <= (probe <= last) || (probe >= first);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {7'b0, res_inwin, res_idx};
            m_axis_tuser  <= res_found;
          end
        end
        default: begin
          res_found <= res_found;
        end
      endcase
    end
  end

endmodule
